// File: rtl/ctfr_pkg.sv
// shared types, constants and helpers for the text frame receiver
package ctfr_pkg;

   localparam int LINE_W       = 8;
   localparam int BYTE_W       = 8;
   localparam int COUNT_W      = 16;
   localparam int FIELD_W      = 5;
   localparam int STATUS_W     = 2;
   localparam int TAIL_W       = 2;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'd13;
   localparam logic [BYTE_W-1:0] CHAR_LF     = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;
   localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;

   localparam logic [STATUS_W-1:0] STATUS_VALID    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FRAME    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CHECKSUM = 2'd2;

   localparam logic [TAIL_W-1:0] TAIL_NONE = 2'd0;
   localparam logic [TAIL_W-1:0] TAIL_ONE  = 2'd1;
   localparam logic [TAIL_W-1:0] TAIL_TWO  = 2'd2;
   localparam logic [TAIL_W-1:0] TAIL_MANY = 2'd3;

   // classified word between front and back
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              is_eol;
      logic              is_dollar;
      logic              is_star;
      logic              is_comma;
   } word_type;

   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nibble);
      logic [BYTE_W-1:0] res;
      if (nibble < 4'd10) begin
         res = 8'h30 + {4'd0, nibble};
      end else begin
         res = 8'h37 + {4'd0, nibble};
      end
      return res;
   endfunction

   function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] res;
      if (c >= 8'h61 && c <= 8'h7A) begin
         res = c - 8'd32;
      end else begin
         res = c;
      end
      return res;
   endfunction

endpackage

// File: rtl/ctfr_queue.sv
// short word queue between classifier and line engine
module ctfr_queue
   import ctfr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  word_type push_word,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output word_type head_word
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   word_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_word  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// File: rtl/ctfr_front.sv
// input side: takes received bytes and classifies them
module ctfr_front
   import ctfr_pkg::*;
(
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic              queue_full,
   output logic              push,
   output word_type          push_word
);

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_word.data      = req_rx_byte;
      push_word.is_eol    = (req_rx_byte == CHAR_CR) || (req_rx_byte == CHAR_LF);
      push_word.is_dollar = (req_rx_byte == CHAR_DOLLAR);
      push_word.is_star   = (req_rx_byte == CHAR_STAR);
      push_word.is_comma  = (req_rx_byte == CHAR_COMMA);
   end

endmodule

// File: rtl/ctfr_back.sv
// line engine: per-word line state, frame checks and result register
module ctfr_back
   import ctfr_pkg::*;
#(
   parameter int MAX_LINE  = 128,
   parameter int FIELD_CAP = 16
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  word_type            head_word,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [FIELD_W-1:0]  rsp_field_count,
   output logic [LINE_W-1:0]   rsp_payload_start,
   output logic [LINE_W-1:0]   rsp_payload_length,
   output logic [BYTE_W-1:0]   rsp_computed_checksum,
   output logic [COUNT_W-1:0]  rsp_overflow_count
);

   logic [LINE_W-1:0]   line_length_ff, line_length_in;
   logic                overflowed_ff, overflowed_in;
   logic                start_seen_ff, start_seen_in;
   logic [LINE_W-1:0]   start_offset_ff, start_offset_in;
   logic [BYTE_W-1:0]   running_xor_ff, running_xor_in;
   logic [BYTE_W-1:0]   xor_star_ff, xor_star_in;
   logic                star_seen_ff, star_seen_in;
   logic [LINE_W-1:0]   star_offset_ff, star_offset_in;
   logic [TAIL_W-1:0]   tail_count_ff, tail_count_in;
   logic [BYTE_W-1:0]   tail_first_ff, tail_first_in;
   logic [BYTE_W-1:0]   tail_second_ff, tail_second_in;
   logic [LINE_W-1:0]   comma_total_ff, comma_total_in;
   logic [LINE_W-1:0]   comma_star_ff, comma_star_in;
   logic [COUNT_W-1:0]  discard_ff, discard_in;

   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [FIELD_W-1:0]  out_fields_ff, out_fields_in;
   logic [LINE_W-1:0]   out_start_ff, out_start_in;
   logic [LINE_W-1:0]   out_length_ff, out_length_in;
   logic [BYTE_W-1:0]   out_checksum_ff, out_checksum_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;

   logic slot_free;
   logic emit;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign pop       = head_valid && (!head_word.is_eol || slot_free);
   assign emit      = pop && head_word.is_eol && (line_length_ff != '0) && !overflowed_ff;

   always_comb begin
      line_length_in  = line_length_ff;
      overflowed_in   = overflowed_ff;
      start_seen_in   = start_seen_ff;
      start_offset_in = start_offset_ff;
      running_xor_in  = running_xor_ff;
      xor_star_in     = xor_star_ff;
      star_seen_in    = star_seen_ff;
      star_offset_in  = star_offset_ff;
      tail_count_in   = tail_count_ff;
      tail_first_in   = tail_first_ff;
      tail_second_in  = tail_second_ff;
      comma_total_in  = comma_total_ff;
      comma_star_in   = comma_star_ff;
      discard_in      = discard_ff;
      if (pop) begin
         if (head_word.is_eol) begin
            if (line_length_ff != '0) begin
               line_length_in  = '0;
               overflowed_in   = 1'b0;
               start_seen_in   = 1'b0;
               start_offset_in = '0;
               running_xor_in  = '0;
               xor_star_in     = '0;
               star_seen_in    = 1'b0;
               star_offset_in  = '0;
               tail_count_in   = TAIL_NONE;
               tail_first_in   = '0;
               tail_second_in  = '0;
               comma_total_in  = '0;
               comma_star_in   = '0;
            end
         end else if (line_length_ff >= LINE_W'(MAX_LINE)) begin
            if (!overflowed_ff) begin
               overflowed_in = 1'b1;
               discard_in    = discard_ff + 1'b1;
            end
         end else begin
            if (!start_seen_ff) begin
               if (head_word.is_dollar) begin
                  start_seen_in   = 1'b1;
                  start_offset_in = line_length_ff + 1'b1;
               end
            end else begin
               if (head_word.is_star) begin
                  star_seen_in   = 1'b1;
                  star_offset_in = line_length_ff;
                  xor_star_in    = running_xor_ff;
                  comma_star_in  = comma_total_ff;
                  tail_count_in  = TAIL_NONE;
               end else if (star_seen_ff) begin
                  if (tail_count_ff == TAIL_NONE) begin
                     tail_first_in = head_word.data;
                  end else if (tail_count_ff == TAIL_ONE) begin
                     tail_second_in = head_word.data;
                  end
                  if (tail_count_ff != TAIL_MANY) begin
                     tail_count_in = tail_count_ff + 1'b1;
                  end
               end
               if (head_word.is_comma) begin
                  comma_total_in = comma_total_ff + 1'b1;
               end
               running_xor_in = running_xor_ff ^ head_word.data;
            end
            line_length_in = line_length_ff + 1'b1;
         end
      end
   end

   // frame checks on the finished line
   always_comb begin
      out_status_in   = STATUS_VALID;
      out_fields_in   = '0;
      out_start_in    = '0;
      out_length_in   = '0;
      out_checksum_in = '0;
      out_count_in    = discard_ff;
      if (!start_seen_ff) begin
         out_status_in = STATUS_FRAME;
      end else begin
         out_start_in = start_offset_ff;
         if (!star_seen_ff) begin
            out_status_in = STATUS_CHECKSUM;
         end else begin
            out_length_in   = star_offset_ff - start_offset_ff;
            out_checksum_in = xor_star_ff;
            if (tail_count_ff != TAIL_TWO) begin
               out_status_in = STATUS_CHECKSUM;
            end else if (upcase(tail_first_ff) != hex_char(xor_star_ff[7:4]) ||
                         upcase(tail_second_ff) != hex_char(xor_star_ff[3:0])) begin
               out_status_in = STATUS_CHECKSUM;
            end else if ({1'b0, comma_star_ff} > 9'(FIELD_CAP)) begin
               out_status_in = STATUS_FRAME;
            end else begin
               out_fields_in = comma_star_ff[FIELD_W-1:0];
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff  <= '0;
         overflowed_ff   <= 1'b0;
         start_seen_ff   <= 1'b0;
         start_offset_ff <= '0;
         running_xor_ff  <= '0;
         xor_star_ff     <= '0;
         star_seen_ff    <= 1'b0;
         star_offset_ff  <= '0;
         tail_count_ff   <= TAIL_NONE;
         tail_first_ff   <= '0;
         tail_second_ff  <= '0;
         comma_total_ff  <= '0;
         comma_star_ff   <= '0;
         discard_ff      <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         line_length_ff  <= line_length_in;
         overflowed_ff   <= overflowed_in;
         start_seen_ff   <= start_seen_in;
         start_offset_ff <= start_offset_in;
         running_xor_ff  <= running_xor_in;
         xor_star_ff     <= xor_star_in;
         star_seen_ff    <= star_seen_in;
         star_offset_ff  <= star_offset_in;
         tail_count_ff   <= tail_count_in;
         tail_first_ff   <= tail_first_in;
         tail_second_ff  <= tail_second_in;
         comma_total_ff  <= comma_total_in;
         comma_star_ff   <= comma_star_in;
         discard_ff      <= discard_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_status_ff   <= out_status_in;
         out_fields_ff   <= out_fields_in;
         out_start_ff    <= out_start_in;
         out_length_ff   <= out_length_in;
         out_checksum_ff <= out_checksum_in;
         out_count_ff    <= out_count_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = out_status_ff;
   assign rsp_field_count       = out_fields_ff;
   assign rsp_payload_start     = out_start_ff;
   assign rsp_payload_length    = out_length_ff;
   assign rsp_computed_checksum = out_checksum_ff;
   assign rsp_overflow_count    = out_count_ff;

endmodule

// File: rtl/checksummed_text_frame_receiver_core.sv
// top level of the checksummed text frame receiver
//
//  channel | direction | ports                         | transfer
//  req     | in        | req_valid/req_ready/rx_byte   | one received byte per word
//  rsp     | out       | rsp_valid/rsp_ready/fields    | one word per non-empty unoverflowed line
//
//  one byte per cycle unless a line end waits on rsp_ready; bytes are registered in the queue
//  a line's result turns valid at the edge that pops its CR or LF from the two-entry queue
//  synchronous reset clears the queue, the line state, the overflow count and the result valid
//  req_ready drops only when the queue is full; it fills while a line end waits on rsp_ready
module checksummed_text_frame_receiver_core
   import ctfr_pkg::*;
#(
   parameter int MAX_LINE  = 128,
   parameter int FIELD_CAP = 16
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [FIELD_W-1:0]  rsp_field_count,
   output logic [LINE_W-1:0]   rsp_payload_start,
   output logic [LINE_W-1:0]   rsp_payload_length,
   output logic [BYTE_W-1:0]   rsp_computed_checksum,
   output logic [COUNT_W-1:0]  rsp_overflow_count
);

   logic     queue_full;
   logic     push;
   word_type push_word;
   logic     pop;
   logic     head_valid;
   word_type head_word;

   ctfr_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .push        (push),
      .push_word   (push_word)
   );

   ctfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (push_word),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_word  (head_word)
   );

   ctfr_back #(
      .MAX_LINE  (MAX_LINE),
      .FIELD_CAP (FIELD_CAP)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_valid            (head_valid),
      .head_word             (head_word),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_field_count       (rsp_field_count),
      .rsp_payload_start     (rsp_payload_start),
      .rsp_payload_length    (rsp_payload_length),
      .rsp_computed_checksum (rsp_computed_checksum),
      .rsp_overflow_count    (rsp_overflow_count)
   );

endmodule
